// ----- hw/rtl/tcae_pkg.sv -----
// Package for the tile cache evictor: slot modes, command and status codes,
// item and result structs, and controller/datapath control types. No dependencies.
`timescale 1ns / 1ps
package tcae_pkg;

  // slot table depth, tied to the 6-bit slot field of the item
  localparam int SLOT_COUNT = 64;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_REF     = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MODE     = 2'd1,
    ST_TMP_REF  = 2'd2,
    ST_SLOT     = 2'd3
  } status_t;

  localparam logic [1:0] MODE_UNLOADED = 2'd0;
  localparam logic [1:0] MODE_LOADED   = 2'd1;
  localparam logic [1:0] MODE_LOCKED   = 2'd2;

  localparam logic [1:0] FETCH_NONE    = 2'd0;
  localparam logic [1:0] FETCH_RESTORE = 2'd1;
  localparam logic [1:0] FETCH_REGEN   = 2'd2;

  localparam int FLAG_TMP = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_VAR = 2;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] tile_slot;
    logic [2:0] tile_flags;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] fetch_action;
    logic       self_unloaded;
    logic       self_saved;
    logic       evicted;
    logic [5:0] evicted_slot;
    logic       evicted_saved;
    logic [6:0] resident_count;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DECIDE,
    S_SCAN,
    S_SCAN_END,
    S_APPLY,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;   // capture command
    logic rd_slot;     // read addressed slot
    logic decide;      // decide action from slot record
    logic scan_start;  // clear scan counter and best
    logic scan_step;   // age one slot and compare
    logic evict;       // apply victim
    logic apply;       // write addressed slot
    logic emit;        // drive result strobe
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic need_prune;  // over limit for the current command
    logic prune_first; // prune before the self update (reference)
    logic scan_last;   // last slot being visited
  } sts_t;

endpackage

// ----- hw/rtl/tcae_ctrl.sv -----
// Controller state machine for the tile cache evictor.
// Depends on tcae_pkg.
`timescale 1ns / 1ps
module tcae_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tcae_pkg::sts_t sts,
  output tcae_pkg::ctl_t ctl
);
  import tcae_pkg::*;

  state_t state, state_next;
  logic   pruned, pruned_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pruned <= 1'b0;
    end else begin
      state  <= state_next;
      pruned <= pruned_next;
    end
  end

  // next state; the prune decision is taken in APPLY once status is known
  always_comb begin
    state_next  = state;
    pruned_next = pruned;
    unique case (state)
      S_IDLE: if (start) begin
        state_next  = S_READ;
        pruned_next = 1'b0;
      end
      S_READ:   state_next = S_DECIDE;
      S_DECIDE: state_next = S_APPLY;
      S_SCAN:     if (sts.scan_last) state_next = S_SCAN_END;
      S_SCAN_END: begin
        pruned_next = 1'b1;
        state_next  = sts.prune_first ? S_APPLY : S_DONE;
      end
      S_APPLY: begin
        if (sts.need_prune && !pruned) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:     ctl.load_item = start;
      S_READ:     ctl.rd_slot = 1'b1;
      S_DECIDE: begin
        ctl.decide     = 1'b1;
        ctl.scan_start = 1'b1;
      end
      S_SCAN:     ctl.scan_step = 1'b1;
      S_SCAN_END: ctl.evict = 1'b1;
      S_APPLY: begin
        // a reference that must prune writes its slot only after the scan
        ctl.apply      = sts.prune_first ? !(sts.need_prune && !pruned) : !pruned;
        ctl.scan_start = 1'b1;
      end
      S_DONE:     ctl.emit = 1'b1;
      default:    ctl = '0;
    endcase
  end
endmodule

// ----- hw/rtl/tcae_dp.sv -----
// Datapath of the tile cache evictor: slot table memories, residency counter,
// stamp counter and the serial aging/victim scan. Depends on tcae_pkg.
`timescale 1ns / 1ps
module tcae_dp #(
  parameter int AGE_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  tcae_pkg::item_t  item,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_data,
  input  tcae_pkg::ctl_t   ctl,
  output tcae_pkg::sts_t   sts,
  output logic             strobe,
  output tcae_pkg::result_t res
);
  import tcae_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // record: in_use, mode, flags, age, stamp
  localparam int RW = 1 + 2 + 3 + AGE_BITS + 32;
  typedef struct packed {
    logic                in_use;
    logic [1:0]          mode;
    logic [2:0]          flags;
    logic [AGE_BITS-1:0] age;
    logic [31:0]         stamp;
  } rec_t;

  // table memory with reset by valid bits (in flip-flops, one per slot)
  logic [RW-1:0]         mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;
  logic [RW-1:0]         rd_raw;
  logic [IW-1:0]         rd_addr;
  logic                  rd_valid;
  rec_t                  rd_rec;

  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  rec_t                  wr_rec;

  // registers
  logic [6:0]    capacity;
  logic [CW-1:0] resident;
  logic [31:0]   stamp_ctr;
  item_t         cur;
  logic          slot_ok;
  rec_t          self_rec;
  logic [1:0]    status;
  logic [1:0]    fetch;
  logic          self_unl, self_sav;
  logic          ev, ev_sav;
  logic [5:0]    ev_slot;
  logic          prune_first;

  // scan
  logic [CW-1:0] scan_idx;     // read issued index
  logic          scan_pend;    // a read is in flight
  logic [IW-1:0] scan_addr;    // address of in-flight read
  logic          found;
  logic [IW-1:0] best_idx;
  logic [AGE_BITS-1:0] best_age;
  logic [31:0]   best_since;
  logic          best_sav;
  rec_t          best_rec;     // victim record as read, before ageing

  assign rd_rec = rd_valid ? rec_t'(rd_raw) : '0;

  // read address: scan or addressed slot
  always_comb begin
    if (ctl.scan_step) begin
      rd_addr = scan_idx[IW-1:0];
    end else begin
      rd_addr = cur.tile_slot[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_raw <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr] && !(wr_en && wr_addr == rd_addr);
      if (wr_en) valid[wr_addr] <= 1'b1;
    end
  end

  // decode of the addressed slot (self_rec, captured in DECIDE, valid after it)
  logic tmp_s, syn_s, var_s;
  assign tmp_s = self_rec.flags[FLAG_TMP];
  assign syn_s = self_rec.flags[FLAG_SYN];
  assign var_s = self_rec.flags[FLAG_VAR];

  // limits: reference uses capacity-1, release capacity
  logic [CW-1:0] res_after_self;
  logic          over_ref, over_rel;
  assign over_ref = ({1'b0, resident} >= {1'b0, capacity}) || (capacity == 7'd0);
  always_comb begin
    res_after_self = resident;
    if (var_s || tmp_s) res_after_self = resident - CW'(1);
  end
  assign over_rel = {1'b0, res_after_self} > {1'b0, capacity};

  // status to controller
  logic need_prune;
  always_comb begin
    need_prune = 1'b0;
    if (status == ST_OK) begin
      if (cur.command == CMD_REF) begin
        need_prune = (self_rec.mode == MODE_UNLOADED) && over_ref;
      end else if (cur.command == CMD_RELEASE) begin
        need_prune = over_rel;
      end
    end
  end
  assign sts.need_prune  = need_prune;
  assign sts.prune_first = prune_first;
  assign sts.scan_last   = scan_pend && (scan_idx == CW'(SLOT_COUNT));

  // scan element compare on the record just read
  logic [AGE_BITS-1:0] aged;
  logic                is_res, is_loaded, better;
  logic [31:0]         since;
  assign is_res    = rd_rec.in_use && rd_rec.mode != MODE_UNLOADED;
  assign is_loaded = rd_rec.in_use && rd_rec.mode == MODE_LOADED;
  assign aged      = (is_res && rd_rec.age != AGE_MAX) ? rd_rec.age + 1'b1 : rd_rec.age;
  assign since     = stamp_ctr - rd_rec.stamp;
  assign better    = is_loaded && (!found || aged > best_age ||
                     (aged == best_age && since > best_since));

  // write port mux; the victim is written back from its captured record
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur.tile_slot[IW-1:0];
    wr_rec  = self_rec;
    if (ctl.scan_step && scan_pend) begin
      wr_en      = is_res;
      wr_addr    = scan_addr;
      wr_rec     = rd_rec;
      wr_rec.age = aged;
    end else if (ctl.evict && found) begin
      wr_en       = 1'b1;
      wr_addr     = best_idx;
      wr_rec      = best_rec;
      wr_rec.age  = best_age;
      wr_rec.mode = MODE_UNLOADED;
    end else if (ctl.apply && status == ST_OK) begin
      wr_en  = 1'b1;
      wr_rec = self_rec;
      unique case (cur.command)
        CMD_CREATE: begin
          wr_rec.in_use = 1'b1;
          wr_rec.mode   = MODE_LOCKED;
          wr_rec.flags  = cur.tile_flags;
          wr_rec.age    = '0;
          wr_rec.stamp  = stamp_ctr;
        end
        CMD_REF: begin
          if (self_rec.mode == MODE_UNLOADED) wr_rec.stamp = stamp_ctr;
          if (self_rec.mode != MODE_LOCKED) begin
            wr_rec.mode = MODE_LOCKED;
            wr_rec.age  = '0;
          end
        end
        CMD_RELEASE: wr_rec.mode = (tmp_s || var_s) ? MODE_UNLOADED : MODE_LOADED;
        CMD_DESTROY: wr_rec = '0;
        default:     wr_rec = self_rec;
      endcase
    end
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= 7'd16;
      resident  <= '0;
      stamp_ctr <= '0;
      strobe    <= 1'b0;
      scan_pend <= 1'b0;
      scan_idx  <= '0;
      found     <= 1'b0;
    end else begin
      strobe <= ctl.emit;
      if (cfg_we) capacity <= cfg_data;
      if (ctl.load_item) begin
        cur  <= item;
        ev   <= 1'b0; ev_slot <= '0; ev_sav <= 1'b0;
        self_unl <= 1'b0; self_sav <= 1'b0; fetch <= FETCH_NONE;
        slot_ok <= ({26'd0, item.tile_slot} < 32'(SLOT_COUNT));
        prune_first <= (item.command == CMD_REF);
      end
      if (ctl.decide) begin
        self_rec <= rd_rec;
        status   <= ST_OK;
        if (!slot_ok) begin
          status <= ST_SLOT;
        end else if (cur.command == CMD_CREATE) begin
          if (rd_rec.in_use) status <= ST_SLOT;
        end else if (!rd_rec.in_use) begin
          status <= ST_SLOT;
        end else if (cur.command == CMD_REF) begin
          if (rd_rec.flags[FLAG_TMP]) status <= ST_TMP_REF;
        end else if (cur.command == CMD_RELEASE) begin
          if (rd_rec.mode != MODE_LOCKED) status <= ST_MODE;
        end
      end
      if (ctl.scan_start) begin
        scan_idx  <= '0;
        scan_pend <= 1'b0;
        found     <= 1'b0;
      end
      if (ctl.scan_step) begin
        scan_addr <= scan_idx[IW-1:0];
        scan_pend <= 1'b1;
        if (scan_idx != CW'(SLOT_COUNT)) scan_idx <= scan_idx + CW'(1);
        if (scan_pend && better) begin
          found      <= 1'b1;
          best_idx   <= scan_addr;
          best_age   <= aged;
          best_since <= since;
          best_rec   <= rd_rec;
          best_sav   <= (rd_rec.flags[FLAG_TMP] | rd_rec.flags[FLAG_SYN]) == 1'b0;
        end
      end
      if (ctl.evict && found) begin
        ev       <= 1'b1;
        ev_slot  <= 6'(best_idx);
        ev_sav   <= best_sav;
        resident <= resident - CW'(1);
        // the addressed slot may be the victim
        if (best_idx == cur.tile_slot[IW-1:0]) self_rec.mode <= MODE_UNLOADED;
      end
      if (ctl.apply && status == ST_OK) begin
        unique case (cur.command)
          CMD_CREATE: begin
            resident  <= resident + CW'(1);
            stamp_ctr <= stamp_ctr + 32'd1;
          end
          CMD_REF: if (self_rec.mode == MODE_UNLOADED) begin
            resident  <= resident + CW'(1);
            stamp_ctr <= stamp_ctr + 32'd1;
            fetch     <= syn_s ? FETCH_REGEN : FETCH_RESTORE;
          end
          CMD_RELEASE: if (tmp_s || var_s) begin
            resident <= resident - CW'(1);
            self_unl <= 1'b1;
            self_sav <= !(tmp_s || syn_s);
          end
          CMD_DESTROY: if (self_rec.mode != MODE_UNLOADED) begin
            resident <= resident - CW'(1);
            self_unl <= 1'b1;
            self_sav <= !(tmp_s || syn_s);
          end
          default: ;
        endcase
      end
    end
  end

  // result fields
  always_comb begin
    res.status         = status;
    res.fetch_action   = fetch;
    res.self_unloaded  = self_unl;
    res.self_saved     = self_sav;
    res.evicted        = ev;
    res.evicted_slot   = ev_slot;
    res.evicted_saved  = ev_sav;
    res.resident_count = 7'(resident);
  end
endmodule

// ----- hw/rtl/tile_cache_aging_evictor_unit.sv -----
// Top level of the tile cache evictor: controller plus datapath.
// Depends on tcae_pkg, tcae_ctrl, tcae_dp.
`timescale 1ns / 1ps
// One command is taken when start is high and busy low; its result shows for
// one cycle on strobe, which the receiver cannot stall. A command without
// pruning passes through READ, DECIDE, APPLY and DONE, and strobe is
// registered from DONE. Pruning scans the whole slot table, one read per slot,
// after a release or before a reference loads its tile, ending in SCAN_END.
// The next command can be taken in the cycle the result shows. The
// capacity register may be written whenever busy is low.
module tile_cache_aging_evictor_unit #(
  parameter int AGE_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcae_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_data,
  output logic              strobe,
  output tcae_pkg::result_t result
);
  import tcae_pkg::*;

  ctl_t ctl;
  sts_t sts;

  tcae_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .ctl  (ctl)
  );

  tcae_dp #(
    .AGE_BITS  (AGE_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .ctl     (ctl),
    .sts     (sts),
    .strobe  (strobe),
    .res     (result)
  );
endmodule

// ----- hw/rtl/tcae_checker.sv -----
// Port-level checker for the tile cache evictor, bound to the top level.
// Depends on tcae_pkg.
`timescale 1ns / 1ps
module tcae_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input tcae_pkg::result_t result
);
  import tcae_pkg::*;

  // an accepted item makes the block busy
  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item not taken");
  // a result never shows while idle before it
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("stray result");
  // strobe lasts one cycle
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("strobe held");
  // errors carry no actions
  a_err: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status != ST_OK |-> !result.evicted && !result.self_unloaded
      && result.fetch_action == FETCH_NONE) else $error("action on error");
endmodule

bind tile_cache_aging_evictor_unit tcae_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .strobe(strobe), .result(result)
);
